// ----- sv/catm_pkg.sv -----
// Shared types and constants for the CPU access trap mailbox.
`default_nettype none
package catm_pkg;

  // Item kind carried on the input tuser
  typedef enum logic [1:0] {
    ACT_HOST_RD = 2'd0,
    ACT_HOST_WR = 2'd1,
    ACT_TRAP    = 2'd2,
    ACT_UNUSED  = 2'd3
  } action_t;

  // Host register map
  typedef enum logic [1:0] {
    REG_STATUS  = 2'd0,
    REG_CONTROL = 2'd1,
    REG_DATA    = 2'd2,
    REG_ADDR    = 2'd3
  } reg_sel_t;

  // Why the guest CPU is held
  typedef enum logic [1:0] {
    MODE_RUN    = 2'd0,
    MODE_HREAD  = 2'd1,
    MODE_HWRITE = 2'd2
  } halt_mode_t;

  localparam logic [7:0]  ST_READ    = 8'h10;
  localparam logic [7:0]  ST_WORD    = 8'h40;
  localparam logic [7:0]  ST_VALID   = 8'h80;
  localparam logic [3:0]  IO_ADDR_HI = 4'h1;   // bit 16 of an I/O trap address
  localparam logic [15:0] READ_ONES  = 16'hffff;

  // Input item, unpacked
  typedef struct packed {
    action_t     action;
    reg_sel_t    reg_select;
    logic [15:0] host_wdata;
    logic [19:0] cpu_addr;
    logic        cpu_is_io;
    logic        cpu_is_read;
    logic        cpu_is_word;
    logic [15:0] cpu_wdata;
  } in_item_t;

  // Result item, unpacked
  typedef struct packed {
    logic [15:0] host_rdata;
    logic        cpu_release;
    logic [15:0] cpu_return_data;
    logic        running;
    logic [5:0]  irq_levels;
    logic        cpu_reset_pulse;
    logic        trap_refused;
  } result_t;

endpackage
`default_nettype wire

// ----- sv/cpu_access_trap_mailbox_top.sv -----
// Top level of the CPU access trap mailbox: stream ports and result register.
//
// One item is taken per clock while in_tready is high. Each item is either a
// host register read, a host register write or a trapped guest CPU access; it
// updates the mailbox state and yields exactly one result item in the
// following cycle, held in a single output register. Throughput is one item
// per cycle while out_tready is high; the result register is the only stage,
// so in_tready follows out_tready whenever a result is waiting.
`default_nettype none
module cpu_access_trap_mailbox_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] action, [3:2] reg_select
  input  wire logic [3:0]  in_tuser,
  // [15:0] host_wdata, [35:16] cpu_addr, [36] cpu_is_io, [37] cpu_is_read,
  // [38] cpu_is_word, [54:39] cpu_wdata, [55] zero
  input  wire logic [55:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [15:0] host_rdata, [16] cpu_release, [32:17] cpu_return_data,
  // [33] running, [39:34] irq_levels, [40] cpu_reset_pulse,
  // [41] trap_refused, [47:42] zero
  output logic [47:0]      out_tdata
);
  import catm_pkg::*;

  in_item_t    item;
  result_t     result;
  logic        take;
  logic        out_valid_r;
  logic [47:0] out_data_r;

  // Unpack input item
  assign item.action      = action_t'(in_tuser[1:0]);
  assign item.reg_select  = reg_sel_t'(in_tuser[3:2]);
  assign item.host_wdata  = in_tdata[15:0];
  assign item.cpu_addr    = in_tdata[35:16];
  assign item.cpu_is_io   = in_tdata[36];
  assign item.cpu_is_read = in_tdata[37];
  assign item.cpu_is_word = in_tdata[38];
  assign item.cpu_wdata   = in_tdata[54:39];

  // Accept when the result register is empty or draining
  assign in_tready = !out_valid_r || out_tready;
  assign take      = in_tvalid && in_tready;

  catm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_take (take),
    .item      (item),
    .result    (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= {6'b0, result.trap_refused, result.cpu_reset_pulse,
                     result.irq_levels, result.running, result.cpu_return_data,
                     result.cpu_release, result.host_rdata};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ----- sv/catm_core.sv -----
// Mailbox register file: trap latching, host register access and halt control.
`default_nettype none
module catm_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_take,
  input  wire catm_pkg::in_item_t item,
  output catm_pkg::result_t      result
);
  import catm_pkg::*;

  logic [7:0]  status_r,  status_nxt;
  logic [15:0] control_r, control_nxt;
  logic [15:0] taddr_r,   taddr_nxt;
  logic [15:0] tdata_r,   tdata_nxt;
  halt_mode_t  mode_r,    mode_nxt;

  logic        run_now;
  logic [3:0]  addr_hi;
  logic [15:0] wr_data;

  assign run_now = control_r[0] && (mode_r == MODE_RUN);

  // Upper address nibble: I/O ports map to bit 16 only
  assign addr_hi = item.cpu_is_io ? IO_ADDR_HI : item.cpu_addr[19:16];

  // Trapped write data; odd byte writes land in the high byte
  always_comb begin
    if (item.cpu_is_word) begin
      wr_data = item.cpu_wdata;
    end else if (item.cpu_addr[0]) begin
      wr_data = {item.cpu_wdata[7:0], 8'h00};
    end else begin
      wr_data = {8'h00, item.cpu_wdata[7:0]};
    end
  end

  // Next state and result for the current item
  always_comb begin
    status_nxt  = status_r;
    control_nxt = control_r;
    taddr_nxt   = taddr_r;
    tdata_nxt   = tdata_r;
    mode_nxt    = mode_r;

    result.host_rdata      = '0;
    result.cpu_release     = 1'b0;
    result.cpu_return_data = '0;
    result.cpu_reset_pulse = 1'b0;
    result.trap_refused    = 1'b0;

    case (item.action)
      ACT_HOST_RD: begin
        case (item.reg_select)
          REG_STATUS:  result.host_rdata = {8'h00, status_r};
          REG_CONTROL: result.host_rdata = READ_ONES;
          REG_DATA: begin
            result.host_rdata = tdata_r;
            // data read resolves a trapped write
            if (mode_r == MODE_HWRITE) begin
              status_nxt         = status_r & ~ST_VALID;
              mode_nxt           = MODE_RUN;
              result.cpu_release = 1'b1;
            end
          end
          default: result.host_rdata = taddr_r;
        endcase
      end
      ACT_HOST_WR: begin
        if (item.reg_select == REG_CONTROL) begin
          result.cpu_reset_pulse = item.host_wdata[0] && !control_r[0];
          control_nxt            = item.host_wdata;
        end else if (item.reg_select == REG_DATA) begin
          tdata_nxt = item.host_wdata;
          // data write resolves a trapped read
          if (mode_r == MODE_HREAD) begin
            status_nxt             = status_r & ~ST_VALID;
            mode_nxt               = MODE_RUN;
            result.cpu_release     = 1'b1;
            result.cpu_return_data = item.host_wdata;
          end
        end
      end
      ACT_TRAP: begin
        if (!run_now) begin
          result.trap_refused = 1'b1;
        end else begin
          if (!item.cpu_is_read) begin
            tdata_nxt = wr_data;
          end
          taddr_nxt  = item.cpu_addr[15:0];
          status_nxt = {4'h0, addr_hi} | ST_VALID
                     | (item.cpu_is_read ? ST_READ : 8'h00)
                     | (item.cpu_is_word ? ST_WORD : 8'h00);
          mode_nxt   = item.cpu_is_read ? MODE_HREAD : MODE_HWRITE;
        end
      end
      default: ;
    endcase

    result.running    = control_nxt[0] && (mode_nxt == MODE_RUN);
    result.irq_levels = control_nxt[11:6];
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r  <= '0;
      control_r <= '0;
      taddr_r   <= '0;
      tdata_r   <= '0;
      mode_r    <= MODE_RUN;
    end else if (item_take) begin
      status_r  <= status_nxt;
      control_r <= control_nxt;
      taddr_r   <= taddr_nxt;
      tdata_r   <= tdata_nxt;
      mode_r    <= mode_nxt;
    end
  end

endmodule
`default_nettype wire
